[src/rbtd_pkg.sv]
// ---------------------------------------------------------------------------
// rbtd_pkg
// Shared types and constants for the receive buffer tracker with dispatch.
// ---------------------------------------------------------------------------
package rbtd_pkg;

	localparam int RING_DEPTH = 64;
	localparam int NUM_PORTS  = 4;
	localparam int RULE_REGS  = 4;
	localparam int PORT_LIMIT = (NUM_PORTS < RULE_REGS) ? NUM_PORTS : RULE_REGS;

	localparam int IDX_W   = $clog2(RING_DEPTH);
	localparam int PTR_W   = IDX_W + 1;
	localparam int ADDR_W  = 40;
	localparam int TAG_W   = 16;
	localparam int SRC_W   = 5;
	localparam int NET_W   = 8;
	localparam int LEN_W   = 16;
	localparam int STAT_W  = 3;
	localparam int PORT_W  = 2;
	localparam int OCC_W   = 7;
	localparam int CNT_W   = 3;
	localparam int RULE_W  = 42;
	localparam int CIDX_W  = 3;

	// Rule register fields.
	localparam int RULE_NET_LO = 32;
	localparam int RULE_ANY    = 40;
	localparam int RULE_OPEN   = 41;

	// Operation codes.
	localparam logic OP_POST       = 1'b0;
	localparam logic OP_COMPLETION = 1'b1;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] CFG_PORT_COUNT = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_RULE0      = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_RULE1      = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_RULE2      = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_RULE3      = 3'd4;

	typedef enum logic [STAT_W-1:0] {
		RES_POSTED    = 3'd0,
		RES_FULL      = 3'd1,
		RES_DELIVERED = 3'd2,
		RES_NULL_ADDR = 3'd3,
		RES_EMPTY     = 3'd4,
		RES_MISMATCH  = 3'd5,
		RES_NO_PORT   = 3'd6
	} result_code_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

[src/rbtd_ctrl.sv]
// ---------------------------------------------------------------------------
// rbtd_ctrl
// Controller: sequences capture of a transaction and its commit.
// ---------------------------------------------------------------------------
module rbtd_ctrl import rbtd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// Commit waits until the result register can take the result.
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_EXEC: begin
				cmd.commit = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[src/rbtd_datapath.sv]
// ---------------------------------------------------------------------------
// rbtd_datapath
// Datapath: ring memory, pointers, dispatch rules and result register.
// ---------------------------------------------------------------------------
module rbtd_datapath import rbtd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic                cfg_we,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [RULE_W-1:0]   cfg_data,
	input  logic                op,
	input  logic [ADDR_W-1:0]   buffer_addr,
	input  logic [TAG_W-1:0]    buffer_tag,
	input  logic [SRC_W-1:0]    source_id,
	input  logic [NET_W-1:0]    completion_netid,
	input  logic [LEN_W-1:0]    length,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic [PORT_W-1:0]   port,
	output logic [TAG_W-1:0]    out_tag,
	output logic [LEN_W-1:0]    out_length,
	output logic [OCC_W-1:0]    occupancy
);

	localparam int ENTRY_W = ADDR_W + TAG_W;

	// Configuration registers.
	logic [CNT_W-1:0]  port_count_q;
	logic [RULE_W-1:0] rule_q [RULE_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_count_q <= '0;
			for (int i = 0; i < RULE_REGS; i++) begin
				rule_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PORT_COUNT: port_count_q <= cfg_data[CNT_W-1:0];
				CFG_RULE0:      rule_q[0]    <= cfg_data;
				CFG_RULE1:      rule_q[1]    <= cfg_data;
				CFG_RULE2:      rule_q[2]    <= cfg_data;
				CFG_RULE3:      rule_q[3]    <= cfg_data;
				default:        port_count_q <= port_count_q;
			endcase
		end
	end

	// Captured transaction.
	logic              op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [TAG_W-1:0]  tag_q;
	logic [SRC_W-1:0]  src_q;
	logic [NET_W-1:0]  net_q;
	logic [LEN_W-1:0]  len_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			addr_q <= buffer_addr;
			tag_q  <= buffer_tag;
			src_q  <= source_id;
			net_q  <= completion_netid;
			len_q  <= length;
		end
	end

	// Pointers.
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] held;
	logic             full;
	logic             empty;

	assign held  = wr_ptr_q - rd_ptr_q;
	assign full  = (held == PTR_W'(RING_DEPTH));
	assign empty = (held == '0);

	// Ring memory; the read port always looks at the oldest entry.
	logic [ENTRY_W-1:0] ring_mem [RING_DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;
	logic               mem_we;

	assign mem_we = cmd.commit && (op_q == OP_POST) && !full;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[wr_ptr_q[IDX_W-1:0]] <= {addr_q, tag_q};
		end
		rd_data_q <= ring_mem[rd_ptr_q[IDX_W-1:0]];
	end

	logic [ADDR_W-1:0] pop_addr;
	logic [TAG_W-1:0]  pop_tag;
	logic              pop;

	assign pop_addr = rd_data_q[ENTRY_W-1:TAG_W];
	assign pop_tag  = rd_data_q[TAG_W-1:0];
	assign pop      = (op_q == OP_COMPLETION) && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else if (cmd.commit) begin
			if (mem_we) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	// Dispatch: first open port, within the registered count, that accepts
	// the source id and network id.
	logic [CNT_W-1:0]  limit;
	logic              found;
	logic [PORT_W-1:0] sel;

	assign limit = (port_count_q > CNT_W'(PORT_LIMIT)) ? CNT_W'(PORT_LIMIT) : port_count_q;

	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int i = RULE_REGS - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < limit) && rule_q[i][RULE_OPEN] && rule_q[i][src_q]
			    && (rule_q[i][RULE_ANY]
			        || (rule_q[i][RULE_NET_LO +: NET_W] == net_q))) begin
				found = 1'b1;
				sel   = PORT_W'(i);
			end
		end
	end

	// Result of the captured transaction.
	result_code_t      res_code;
	logic [PORT_W-1:0] res_port;
	logic [TAG_W-1:0]  res_tag;
	logic [LEN_W-1:0]  res_len;
	logic [PTR_W-1:0]  held_next;

	always_comb begin
		res_port = '0;
		res_tag  = '0;
		res_len  = '0;
		if (op_q == OP_POST) begin
			res_code = full ? RES_FULL : RES_POSTED;
		end else begin
			if (pop) begin
				res_tag = pop_tag;
			end
			if (addr_q == '0) begin
				res_code = RES_NULL_ADDR;
			end else if (!pop) begin
				res_code = RES_EMPTY;
			end else if (pop_addr != addr_q) begin
				res_code = RES_MISMATCH;
			end else if (found) begin
				res_code = RES_DELIVERED;
				res_port = sel;
				res_len  = len_q;
			end else begin
				res_code = RES_NO_PORT;
			end
		end
	end

	assign held_next = held + PTR_W'(mem_we) - PTR_W'(pop);

	// Result register.
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [PORT_W-1:0] port_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic [LEN_W-1:0]  out_length_q;
	logic [OCC_W-1:0]  occupancy_q;

	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q     <= res_code;
			port_q       <= res_port;
			out_tag_q    <= res_tag;
			out_length_q <= res_len;
			occupancy_q  <= OCC_W'(held_next);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign port       = port_q;
	assign out_tag    = out_tag_q;
	assign out_length = out_length_q;
	assign occupancy  = occupancy_q;

endmodule

[src/rx_buffer_tracker_dispatch.sv]
// ---------------------------------------------------------------------------
// rx_buffer_tracker_dispatch
// Receive buffer ring with completion checking and flow dispatch to ports.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     op, buffer_addr, buffer_tag,
//                                              source_id, completion_netid, length
// out       output     out_valid / out_ready   status, port, out_tag,
//                                              out_length, occupancy
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each input transaction goes through two steps: capture while the ring
// memory reads the oldest entry, then check, update the pointers and
// load the result register. The registered read port of the ring sets this.
// The result register frees the input side: a new transaction is taken while
// the previous result still waits. A stalled output holds the commit step.
// Reset clears the pointers, the port count and the rules; ring contents are
// only read after they are written, so they need no clearing.
//
module rx_buffer_tracker_dispatch import rbtd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// Input transactions.
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  logic [ADDR_W-1:0]   buffer_addr,
	input  logic [TAG_W-1:0]    buffer_tag,
	input  logic [SRC_W-1:0]    source_id,
	input  logic [NET_W-1:0]    completion_netid,
	input  logic [LEN_W-1:0]    length,
	// Result transactions.
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic [PORT_W-1:0]   port,
	output logic [TAG_W-1:0]    out_tag,
	output logic [LEN_W-1:0]    out_length,
	output logic [OCC_W-1:0]    occupancy,
	// Configuration writes.
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [RULE_W-1:0]   cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Configuration writes are taken unchecked; they must only arrive while idle.
	assign cfg_ready = 1'b1;

	// The controller decides when a transaction is captured and committed.
	rbtd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the ring, the rules and the result register.
	rbtd_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.op               (op),
		.buffer_addr      (buffer_addr),
		.buffer_tag       (buffer_tag),
		.source_id        (source_id),
		.completion_netid (completion_netid),
		.length           (length),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.port             (port),
		.out_tag          (out_tag),
		.out_length       (out_length),
		.occupancy        (occupancy)
	);

`ifndef SYNTHESIS
	// Only one transaction is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a transaction is in work");

	// The ring never reports more entries than it has.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occupancy <= OCC_W'(RING_DEPTH)))
		else $error("occupancy beyond ring depth");

	// A refused post means the ring is full.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == RES_FULL)) |-> (occupancy == OCC_W'(RING_DEPTH)))
		else $error("full reported with ring not full");

	// Only a delivered buffer carries a port and a length.
	a_undelivered: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != RES_DELIVERED)) |-> ((port == '0) && (out_length == '0)))
		else $error("port or length set on an undelivered result");
`endif

endmodule
